@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL; escal_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/escal_pkg.sv @@
package escal_pkg;

  localparam int TIME_W = 32;
  localparam int ZONE_W = 17;
  localparam int DAYS_W = 16;
  localparam int YEAR_W = 12;

  localparam logic [TIME_W-1:0] NTP_TO_UNIX  = 32'd2208988800;
  localparam logic [TIME_W-1:0] SEC_PER_DAY  = 32'd86400;
  localparam logic [TIME_W-1:0] SEC_PER_HOUR = 32'd3600;
  localparam logic [TIME_W-1:0] SEC_PER_MIN  = 32'd60;

  localparam logic [ZONE_W-1:0] ZONE_RESET = 17'd7200;

  localparam logic [YEAR_W-1:0] FIRST_YEAR      = 12'd1970;
  localparam logic [YEAR_W-1:0] LAST_QUAD_YEAR  = 12'd2096;
  localparam logic [YEAR_W-1:0] NONLEAP_CENTURY = 12'd2100;
  localparam logic [DAYS_W-1:0] DAYS_PER_QUAD   = 16'd1461;
  localparam logic [DAYS_W-1:0] DAYS_LEAP_YEAR  = 16'd366;
  localparam logic [DAYS_W-1:0] DAYS_COMMON_YR  = 16'd365;
  localparam logic [3:0]        LAST_MONTH      = 4'd11;

  // reciprocal division: q = ((x >> PRE) * RCP) >> SHIFT, exact over the operand range
  // 86400 = 2^7 * 675, dividend below 2^32
  localparam int          DAY_PRE_SHIFT  = 7;
  localparam int          DAY_RCP_SHIFT  = 35;
  localparam logic [25:0] DAY_RCP        = 26'd50903317;
  // 3600 = 2^4 * 225, dividend below 86400
  localparam int          HOUR_PRE_SHIFT = 4;
  localparam int          HOUR_RCP_SHIFT = 21;
  localparam logic [13:0] HOUR_RCP       = 14'd9321;
  // 60 = 2^2 * 15, dividend below 3600
  localparam int          MIN_PRE_SHIFT  = 2;
  localparam int          MIN_RCP_SHIFT  = 14;
  localparam logic [10:0] MIN_RCP        = 11'd1093;
  // 7, dividend below 2^16
  localparam int          WEEK_RCP_SHIFT = 19;
  localparam logic [16:0] WEEK_RCP       = 17'd74899;

  localparam logic CFG_NTP_INPUT   = 1'b0;
  localparam logic CFG_ZONE_OFFSET = 1'b1;

  typedef enum logic [2:0] {
    DV_DAYS = 3'd0,
    DV_SOD  = 3'd1,
    DV_HOUR = 3'd2,
    DV_HREM = 3'd3,
    DV_MIN  = 3'd4,
    DV_SEC  = 3'd5
  } div_phase_t;

  typedef struct packed {
    logic              load;
    logic              div_step;
    div_phase_t        phase;
    logic              yr_step;
    logic              mo_step;
    logic              push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } dp_status_t;

  // valid for years 1970..2106
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (y != NONLEAP_CENTURY);
  endfunction

  function automatic logic [DAYS_W-1:0] month_len(input logic [3:0] m, input logic leap);
    logic [DAYS_W-1:0] len;
    unique case (m)
      4'd1:                      len = leap ? 16'd29 : 16'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 16'd30;
      default:                   len = 16'd31;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/epoch_seconds_to_calendar.sv @@
// Steps from input transaction to result: six conversion phases of reciprocal
//   multiplications, a year search that steps one year (four years at once when possible),
//   a month search that steps one month, and an output step.
// A new transaction is taken only once the previous one is through; the next input is taken while a result waits.
// A stalled result holds the controller before the output cycle.
// Reset (rst_n low, synchronous): controller idle, no result valid, ntp_input 0, offset 7200.
module epoch_seconds_to_calendar
  import escal_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [ZONE_W-1:0]  cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [TIME_W-1:0]  in_time_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second,
  output logic [DAYS_W-1:0]  out_days_since_epoch,
  output logic [2:0]         out_weekday,
  output logic [YEAR_W-1:0]  out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day_of_month,
  output logic               out_leap_year
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  escal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  escal_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_time_seconds      (in_time_seconds),
    .cmd                  (cmd),
    .status               (status),
    .out_hour             (out_hour),
    .out_minute           (out_minute),
    .out_second           (out_second),
    .out_days_since_epoch (out_days_since_epoch),
    .out_weekday          (out_weekday),
    .out_year             (out_year),
    .out_month            (out_month),
    .out_day_of_month     (out_day_of_month),
    .out_leap_year        (out_leap_year)
  );

endmodule

@@ rtl/escal_dp.sv @@
module escal_dp
  import escal_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_index,
  input  logic [ZONE_W-1:0]        cfg_wdata,
  input  logic [TIME_W-1:0]        in_time_seconds,
  input  ctrl_cmd_t                cmd,
  output dp_status_t               status,
  output logic [4:0]               out_hour,
  output logic [5:0]               out_minute,
  output logic [5:0]               out_second,
  output logic [DAYS_W-1:0]        out_days_since_epoch,
  output logic [2:0]               out_weekday,
  output logic [YEAR_W-1:0]        out_year,
  output logic [3:0]               out_month,
  output logic [4:0]               out_day_of_month,
  output logic                     out_leap_year
);

  logic              ntp_r;
  logic [ZONE_W-1:0] zone_r;

  logic [TIME_W-1:0] rem_r;
  logic [2:0]        wkq_r;
  logic [DAYS_W-1:0] days_r;
  logic [4:0]        hour_r;
  logic [5:0]        minute_r;
  logic [5:0]        second_r;
  logic [2:0]        weekday_r;
  logic [DAYS_W-1:0] yrem_r;
  logic [YEAR_W-1:0] year_r;
  logic [3:0]        month_r;

  logic [4:0]        o_hour_r;
  logic [5:0]        o_minute_r;
  logic [5:0]        o_second_r;
  logic [DAYS_W-1:0] o_days_r;
  logic [2:0]        o_weekday_r;
  logic [YEAR_W-1:0] o_year_r;
  logic [3:0]        o_month_r;
  logic [4:0]        o_dom_r;
  logic              o_leap_r;

  logic [TIME_W-1:0] base_time;
  logic [TIME_W-1:0] local_time;
  logic [24:0]       day_x;
  logic [50:0]       day_prod;
  logic [DAYS_W-1:0] day_quo;
  logic [TIME_W-1:0] day_secs;
  logic [32:0]       week_prod;
  logic [2:0]        week_quo;
  logic [12:0]       hour_x;
  logic [26:0]       hour_prod;
  logic [4:0]        hour_quo;
  logic [TIME_W-1:0] hour_secs;
  logic [9:0]        min_x;
  logic [20:0]       min_prod;
  logic [5:0]        min_quo;
  logic [TIME_W-1:0] min_secs;
  logic [TIME_W-1:0] sec_full;
  logic              leap;
  logic [DAYS_W-1:0] year_len;
  logic              quad_ok;
  logic [DAYS_W-1:0] mlen;

  // NTP to Unix and zone offset, both mod 2^32
  assign base_time  = ntp_r ? (in_time_seconds - NTP_TO_UNIX) : in_time_seconds;
  assign local_time = base_time + {{(TIME_W-ZONE_W){zone_r[ZONE_W-1]}}, zone_r};

  assign day_x     = rem_r[TIME_W-1:DAY_PRE_SHIFT];
  assign day_prod  = 51'(day_x) * 51'(DAY_RCP);
  assign day_quo   = day_prod[DAY_RCP_SHIFT +: DAYS_W];
  assign day_secs  = TIME_W'(days_r) * SEC_PER_DAY;

  // low three quotient bits are enough: days - 7q = days + q mod 8
  assign week_prod = 33'(days_r) * 33'(WEEK_RCP);
  assign week_quo  = week_prod[WEEK_RCP_SHIFT +: 3];

  assign hour_x    = rem_r[16:HOUR_PRE_SHIFT];
  assign hour_prod = 27'(hour_x) * 27'(HOUR_RCP);
  assign hour_quo  = hour_prod[HOUR_RCP_SHIFT +: 5];
  assign hour_secs = TIME_W'(hour_r) * SEC_PER_HOUR;

  assign min_x     = rem_r[11:MIN_PRE_SHIFT];
  assign min_prod  = 21'(min_x) * 21'(MIN_RCP);
  assign min_quo   = min_prod[MIN_RCP_SHIFT +: 6];
  assign min_secs  = TIME_W'(minute_r) * SEC_PER_MIN;
  assign sec_full  = rem_r - min_secs;

  assign leap     = is_leap(year_r);
  assign year_len = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YR;
  // four consecutive years clear of the non-leap century hold exactly one leap day
  assign quad_ok  = (year_r <= LAST_QUAD_YEAR) && (yrem_r >= DAYS_PER_QUAD);
  assign mlen     = month_len(month_r, leap);

  assign status.year_done  = !quad_ok && (yrem_r < year_len);
  assign status.month_done = (month_r == LAST_MONTH) || (yrem_r < mlen);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ntp_r  <= 1'b0;
      zone_r <= ZONE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_NTP_INPUT:   ntp_r  <= cfg_wdata[0];
        CFG_ZONE_OFFSET: zone_r <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= local_time;
    end else if (cmd.div_step) begin
      unique case (cmd.phase)
        DV_DAYS: days_r <= day_quo;
        DV_SOD: begin
          rem_r   <= rem_r - day_secs;
          wkq_r   <= week_quo;
          yrem_r  <= days_r;
          year_r  <= FIRST_YEAR;
          month_r <= '0;
        end
        DV_HOUR: begin
          hour_r    <= hour_quo;
          weekday_r <= days_r[2:0] + wkq_r;
        end
        DV_HREM: rem_r    <= rem_r - hour_secs;
        DV_MIN:  minute_r <= min_quo;
        DV_SEC:  second_r <= sec_full[5:0];
        default: ;
      endcase
    end

    if (cmd.yr_step && !status.year_done) begin
      if (quad_ok) begin
        yrem_r <= yrem_r - DAYS_PER_QUAD;
        year_r <= year_r + 12'd4;
      end else begin
        yrem_r <= yrem_r - year_len;
        year_r <= year_r + 12'd1;
      end
    end else if (cmd.mo_step && !status.month_done) begin
      yrem_r  <= yrem_r - mlen;
      month_r <= month_r + 4'd1;
    end

    if (cmd.push) begin
      o_hour_r    <= hour_r;
      o_minute_r  <= minute_r;
      o_second_r  <= second_r;
      o_days_r    <= days_r;
      o_weekday_r <= weekday_r;
      o_year_r    <= year_r;
      o_month_r   <= month_r + 4'd1;
      o_dom_r     <= yrem_r[4:0] + 5'd1;
      o_leap_r    <= leap;
    end
  end

  assign out_hour             = o_hour_r;
  assign out_minute           = o_minute_r;
  assign out_second           = o_second_r;
  assign out_days_since_epoch = o_days_r;
  assign out_weekday          = o_weekday_r;
  assign out_year             = o_year_r;
  assign out_month            = o_month_r;
  assign out_day_of_month     = o_dom_r;
  assign out_leap_year        = o_leap_r;

endmodule

@@ rtl/escal_ctrl.sv @@
`include "assert_macros.svh"

module escal_ctrl
  import escal_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b0_0001,
    ST_DIV   = 5'b0_0010,
    ST_YEAR  = 5'b0_0100,
    ST_MONTH = 5'b0_1000,
    ST_PUSH  = 5'b1_0000
  } state_t;

  state_t     state_r, state_nxt;
  div_phase_t phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = state_r != ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.phase = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
          phase_nxt = DV_DAYS;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        unique case (phase_r)
          DV_DAYS: phase_nxt = DV_SOD;
          DV_SOD:  phase_nxt = DV_HOUR;
          DV_HOUR: phase_nxt = DV_HREM;
          DV_HREM: phase_nxt = DV_MIN;
          DV_MIN:  phase_nxt = DV_SEC;
          DV_SEC: begin
            phase_nxt = DV_DAYS;
            state_nxt = ST_YEAR;
          end
          default: phase_nxt = DV_DAYS;
        endcase
      end
      ST_YEAR: begin
        cmd.yr_step = 1'b1;
        if (status.year_done) begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        cmd.mo_step = 1'b1;
        if (status.month_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.push ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= DV_DAYS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_IMPLIES(a_push_needs_room, clk, rst_n, cmd.push, !out_valid_r || !out_stall)
  `ASSERT_NEXT(a_accept_starts_div, clk, rst_n, in_valid && !in_stall, state_r == ST_DIV)
  `ASSERT_NEXT(a_push_sets_valid, clk, rst_n, cmd.push, out_valid_r)

endmodule

@@ verif/epoch_seconds_to_calendar_tb.sv @@
module epoch_seconds_to_calendar_tb;
  import escal_pkg::*;

  typedef struct packed {
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [DAYS_W-1:0] days;
    logic [2:0]        weekday;
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        mday;
    logic              leap;
  } calendar_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_wr_en = 1'b0;
  logic              cfg_index = 1'b0;
  logic [ZONE_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TIME_W-1:0] in_time_seconds = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  calendar_t         got;

  logic [TIME_W-1:0] pend_secs[$];
  calendar_t         calendar_q[$];

  logic              model_ntp = 1'b0;
  logic [ZONE_W-1:0] model_zone = ZONE_RESET;

  logic calm = 1'b0;
  int   accepted = 0;
  int   checked = 0;
  int   fails = 0;
  int   n_settings = 0;
  int   hold_cnt = 0;
  logic hold_done = 1'b0;

  epoch_seconds_to_calendar u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_time_seconds      (in_time_seconds),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_hour             (got.hour),
    .out_minute           (got.minute),
    .out_second           (got.second),
    .out_days_since_epoch (got.days),
    .out_weekday          (got.weekday),
    .out_year             (got.year),
    .out_month            (got.month),
    .out_day_of_month     (got.mday),
    .out_leap_year        (got.leap)
  );

  initial forever #6 clk = ~clk;

  function automatic logic gregorian_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic calendar_t to_calendar(input logic [TIME_W-1:0] secs);
    int unsigned mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    logic [TIME_W-1:0] t;
    int unsigned sod, days, rem, yr, mo, len;
    calendar_t c;
    t = secs;
    if (model_ntp)
      t = t - NTP_TO_UNIX;
    t = t + {{(TIME_W-ZONE_W){model_zone[ZONE_W-1]}}, model_zone};
    sod = t % SEC_PER_DAY;
    days = t / SEC_PER_DAY;
    yr = 1970;
    rem = days;
    forever begin
      len = gregorian_leap(yr) ? 366 : 365;
      if (rem < len)
        break;
      rem -= len;
      yr++;
    end
    mo = 0;
    while (mo < 11) begin
      len = mlen[mo] + ((mo == 1 && gregorian_leap(yr)) ? 1 : 0);
      if (rem < len)
        break;
      rem -= len;
      mo++;
    end
    c.hour    = 5'(sod / 3600);
    c.minute  = 6'((sod % 3600) / 60);
    c.second  = 6'(sod % 60);
    c.days    = DAYS_W'(days);
    c.weekday = 3'(days % 7);
    c.year    = YEAR_W'(yr);
    c.month   = 4'(mo + 1);
    c.mday    = 5'(rem + 1);
    c.leap    = gregorian_leap(yr);
    return c;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        calendar_q.push_back(to_calendar(in_time_seconds));
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pend_secs.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
          in_valid <= 1'b1;
          in_time_seconds <= pend_secs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, while the sender still has plenty queued
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && accepted >= 150 && pend_secs.size() > 50) begin
      hold_cnt <= 400;
      hold_done <= 1'b1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    calendar_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (calendar_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("ERROR: result with no transaction pending: %0d-%0d-%0d", got.year,
                     got.month, got.mday);
        end else begin
          want = calendar_q.pop_front();
          checked++;
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("ERROR: exp %0d-%0d-%0d %0d:%0d:%0d days %0d wd %0d leap %0d",
                       want.year, want.month, want.mday, want.hour, want.minute,
                       want.second, want.days, want.weekday, want.leap);
              $display("       got %0d-%0d-%0d %0d:%0d:%0d days %0d wd %0d leap %0d",
                       got.year, got.month, got.mday, got.hour, got.minute,
                       got.second, got.days, got.weekday, got.leap);
            end
          end
        end
      end
      out_stall <= (hold_cnt != 0) || (!calm && $urandom_range(99) < 20);
    end
  end

  task automatic wait_idle();
    while (pend_secs.size() != 0 || in_valid || calendar_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ZONE_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_cfg(input logic ntp, input logic signed [ZONE_W-1:0] zone);
    logic [ZONE_W-1:0] w;
    wait_idle();
    w = ZONE_W'($urandom_range(2 ** ZONE_W - 1));
    w[0] = ntp;
    write_reg(CFG_NTP_INPUT, w);
    write_reg(CFG_ZONE_OFFSET, zone);
    model_ntp = ntp;
    model_zone = zone;
    n_settings++;
  endtask

  initial begin
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] shift;
    logic signed [ZONE_W-1:0] zone;
    int mode;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: Unix input, +2h
    pend_secs.push_back(32'd0);
    pend_secs.push_back(32'hFFFF_FFFF);

    set_cfg(1'b0, '0);
    // leap days, the 2100 non-leap century, year ends
    pend_secs.push_back(32'd68169600);
    pend_secs.push_back(32'd951782400);
    pend_secs.push_back(32'd951868800);
    pend_secs.push_back(32'd4107542399);
    pend_secs.push_back(32'd4107542400);
    pend_secs.push_back(32'd1735689599);
    pend_secs.push_back(32'hFFFF_FFFF);

    set_cfg(1'b1, ZONE_W'(-50400));
    pend_secs.push_back(32'd0);
    pend_secs.push_back(NTP_TO_UNIX);
    pend_secs.push_back(NTP_TO_UNIX - 1);
    pend_secs.push_back(32'hFFFF_FFFF);

    // offset patterns outside the nominal range
    set_cfg(1'b0, ZONE_W'(-65536));
    pend_secs.push_back(32'd0);
    pend_secs.push_back(32'd65535);
    pend_secs.push_back(32'hFFFF_FFFF);

    set_cfg(1'b0, ZONE_W'(65535));
    pend_secs.push_back(32'hFFFF_FFFF);
    pend_secs.push_back(32'hFFFF_0000);
    pend_secs.push_back(32'd0);

    set_cfg(1'b1, ZONE_W'(50400));
    pend_secs.push_back(NTP_TO_UNIX - 32'd50400);
    pend_secs.push_back(NTP_TO_UNIX + 32'd4107542400 - 32'd50400);

    for (int ph = 0; ph < 8; ph++) begin
      mode = $urandom_range(3);
      case (mode)
        0: zone = ZONE_W'(int'($urandom_range(100800)) - 50400);
        1: zone = ZONE_W'($urandom_range(1) ? 50400 : -50400);
        2: zone = ZONE_W'($urandom_range(2 ** ZONE_W - 1));
        default: zone = ZONE_W'($urandom_range(1) ? 7200 : 0);
      endcase
      set_cfg(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'(($urandom_range(1))), zone);
      calm <= (ph == 3);
      shift = (model_ntp ? NTP_TO_UNIX : 32'd0)
              - {{(TIME_W-ZONE_W){model_zone[ZONE_W-1]}}, model_zone};
      for (int i = 0; i < 250; i++) begin
        if ($urandom_range(9) < 5) begin
          t = $urandom();
        end else begin
          // land within a few seconds of a local midnight
          t = $urandom_range(49710) * SEC_PER_DAY + $urandom_range(6) - 3;
          t = t + shift;
        end
        pend_secs.push_back(t);
      end
    end

    wait_idle();
    calm <= 1'b0;
    repeat (200) @(posedge clk);
    $display("summary: %0d conversions checked across %0d register settings",
             checked, n_settings);
    $display("summary: leap days, 2100, wraps and offset extremes directed; %0d errors",
             fails);
    if (fails == 0 && calendar_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("timeout with %0d transactions outstanding", calendar_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule
